>>> rtl/erbj_pkg.sv
// ============================================================================
// erbj_pkg
// Shared constants, types and arithmetic helpers for the rigid body point
// transform and rotational Jacobian pipeline.
// ============================================================================
package erbj_pkg;

	localparam int COORD_WIDTH_DEF   = 32;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int MAX_STAGES        = 24;
	localparam int AXIS_W            = 48;
	localparam int IO_W              = 32;
	localparam int ANG_W             = 16;
	localparam int Q_W               = 34;   // quaternion / cordic word
	localparam int M_W               = 32;   // matrix entry

	localparam logic [1:0] REG_AXIS_ALPHA = 2'd0;
	localparam logic [1:0] REG_AXIS_BETA  = 2'd1;
	localparam logic [1:0] REG_AXIS_GAMMA = 2'd2;

	localparam logic signed [Q_W-1:0] PI_Q30   = 34'sd3373259426;
	localparam logic signed [Q_W-1:0] PIH_Q30  = 34'sd1686629713;
	localparam logic signed [Q_W-1:0] GAIN_Q30 = 34'sd652032874;
	localparam logic signed [Q_W-1:0] ONE_Q30  = 34'sd1073741824;

	typedef logic [AXIS_W-1:0] axis_t;

	typedef struct packed {
		logic signed [M_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	} mat_t;

	// cordic arctangent table, Q.30
	function automatic logic signed [Q_W-1:0] atan_q30(input int i);
		logic signed [Q_W-1:0] r;
		unique case (i)
			0: r = 34'sd843314857;
			1: r = 34'sd497837829;
			2: r = 34'sd263043837;
			3: r = 34'sd133525159;
			4: r = 34'sd67021687;
			5: r = 34'sd33543516;
			6: r = 34'sd16775851;
			7: r = 34'sd8388437;
			8: r = 34'sd4194283;
			9: r = 34'sd2097149;
			default: r = Q_W'(64'sd1 << (30 - i));
		endcase
		return r;
	endfunction

	// signed saturation of a 96-bit value to w bits
	function automatic logic signed [95:0] sat96(input logic signed [95:0] v, input int w);
		logic signed [95:0] lim;
		lim = 96'sd1 <<< (w - 1);
		if (v >= lim)
			return lim - 96'sd1;
		else if (v < -lim)
			return -lim;
		return v;
	endfunction

	// rounded quaternion product, floor((p*q + 2^29) / 2^30)
	function automatic logic signed [Q_W+1:0] pq(input logic signed [Q_W-1:0] p,
			input logic signed [Q_W-1:0] q);
		logic signed [2*Q_W-1:0] t;
		t = p * q + (2*Q_W)'(64'sd536870912);
		return (Q_W+2)'(t >>> 30);
	endfunction

endpackage

>>> rtl/erbj_if.sv
// ============================================================================
// erbj_in_if / erbj_out_if / erbj_cfg_if
// Valid-ready channels of the rigid body Jacobian block.
// ============================================================================
interface erbj_in_if;
	logic valid;
	logic ready;
	logic func;
	logic signed [31:0] pos_x, pos_y, pos_z;
	logic signed [15:0] angle_alpha, angle_beta, angle_gamma;
	logic signed [31:0] loc_x, loc_y, loc_z;
	modport source (output valid, func, pos_x, pos_y, pos_z, angle_alpha, angle_beta,
		angle_gamma, loc_x, loc_y, loc_z, input ready);
	modport sink (input valid, func, pos_x, pos_y, pos_z, angle_alpha, angle_beta,
		angle_gamma, loc_x, loc_y, loc_z, output ready);
endinterface

interface erbj_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] glob_x, glob_y, glob_z;
	logic signed [31:0] dalpha_x, dalpha_y, dalpha_z;
	logic signed [31:0] dbeta_x, dbeta_y, dbeta_z;
	logic signed [31:0] dgamma_x, dgamma_y, dgamma_z;
	modport source (output valid, glob_x, glob_y, glob_z, dalpha_x, dalpha_y, dalpha_z,
		dbeta_x, dbeta_y, dbeta_z, dgamma_x, dgamma_y, dgamma_z, input ready);
	modport sink (input valid, glob_x, glob_y, glob_z, dalpha_x, dalpha_y, dalpha_z,
		dbeta_x, dbeta_y, dbeta_z, dgamma_x, dgamma_y, dgamma_z, output ready);
endinterface

interface erbj_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [47:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/erbj_mat.sv
// ============================================================================
// erbj_mat
// Pipelined CORDIC half-angle sine/cosine and quaternion-to-matrix unit.
// Advances when en is high.
// ============================================================================
module erbj_mat
	import erbj_pkg::*;
#(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic                     clk,
	input  logic                     en,
	input  axis_t                    axis,
	input  logic signed [ANG_W-1:0]  angle,
	output mat_t                     mat
);

	logic signed [Q_W-1:0] x_s [CORDIC_STAGES+1];
	logic signed [Q_W-1:0] y_s [CORDIC_STAGES+1];
	logic signed [Q_W-1:0] z_s [CORDIC_STAGES+1];
	axis_t                 ax_s [CORDIC_STAGES+1];
	logic signed [Q_W-1:0] h;

	// half angle folded into [-pi/2, pi/2]
	always_comb begin
		h = Q_W'(angle) <<< 17;
		if (h > PIH_Q30)
			h = h - PI_Q30;
		else if (h < -PIH_Q30)
			h = h + PI_Q30;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]  <= GAIN_Q30;
			y_s[0]  <= '0;
			z_s[0]  <= h;
			ax_s[0] <= axis;
		end
	end

	// one cordic rotation per stage
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (en) begin
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_q30(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_q30(i);
				end
				ax_s[i+1] <= ax_s[i];
			end
		end
	end

	// quaternion vector part
	logic signed [Q_W-1:0] w_q, qx_q, qy_q, qz_q;
	always_ff @(posedge clk) begin
		logic signed [Q_W+16:0] tx, ty, tz;
		if (en) begin
			tx = $signed(ax_s[CORDIC_STAGES][15:0]) * y_s[CORDIC_STAGES] + 51'sd8192;
			ty = $signed(ax_s[CORDIC_STAGES][31:16]) * y_s[CORDIC_STAGES] + 51'sd8192;
			tz = $signed(ax_s[CORDIC_STAGES][47:32]) * y_s[CORDIC_STAGES] + 51'sd8192;
			w_q  <= x_s[CORDIC_STAGES];
			qx_q <= Q_W'(tx >>> 14);
			qy_q <= Q_W'(ty >>> 14);
			qz_q <= Q_W'(tz >>> 14);
		end
	end

	// quaternion products
	logic signed [Q_W+1:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, xw_q, yw_q, zw_q;
	always_ff @(posedge clk) begin
		if (en) begin
			xx_q <= pq(qx_q, qx_q); yy_q <= pq(qy_q, qy_q); zz_q <= pq(qz_q, qz_q);
			xy_q <= pq(qx_q, qy_q); xz_q <= pq(qx_q, qz_q); yz_q <= pq(qy_q, qz_q);
			xw_q <= pq(qx_q, w_q);  yw_q <= pq(qy_q, w_q);  zw_q <= pq(qz_q, w_q);
		end
	end

	function automatic logic signed [M_W-1:0] ent(input logic signed [Q_W+3:0] v);
		return M_W'(sat96(96'(v), M_W));
	endfunction

	// matrix entries
	always_ff @(posedge clk) begin
		if (en) begin
			mat.m00 <= ent((Q_W+4)'(ONE_Q30) - 2 * ((Q_W+4)'(yy_q) + zz_q));
			mat.m01 <= ent(2 * ((Q_W+4)'(xy_q) - zw_q));
			mat.m02 <= ent(2 * ((Q_W+4)'(xz_q) + yw_q));
			mat.m10 <= ent(2 * ((Q_W+4)'(xy_q) + zw_q));
			mat.m11 <= ent((Q_W+4)'(ONE_Q30) - 2 * ((Q_W+4)'(xx_q) + zz_q));
			mat.m12 <= ent(2 * ((Q_W+4)'(yz_q) - xw_q));
			mat.m20 <= ent(2 * ((Q_W+4)'(xz_q) - yw_q));
			mat.m21 <= ent(2 * ((Q_W+4)'(yz_q) + xw_q));
			mat.m22 <= ent((Q_W+4)'(ONE_Q30) - 2 * ((Q_W+4)'(xx_q) + yy_q));
		end
	end

endmodule

>>> rtl/erbj_mv.sv
// ============================================================================
// erbj_mv
// Two-stage matrix times vector: products registered, then summed and
// saturated to the coordinate width.
// ============================================================================
module erbj_mv
	import erbj_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          en,
	input  mat_t                          mat,
	input  logic signed [COORD_WIDTH-1:0] vx,
	input  logic signed [COORD_WIDTH-1:0] vy,
	input  logic signed [COORD_WIDTH-1:0] vz,
	output logic signed [COORD_WIDTH-1:0] rx,
	output logic signed [COORD_WIDTH-1:0] ry,
	output logic signed [COORD_WIDTH-1:0] rz
);

	localparam int P_W = M_W + COORD_WIDTH;

	logic signed [P_W-1:0] p_s1 [9];

	function automatic logic signed [P_W-1:0] mq(input logic signed [M_W-1:0] m,
			input logic signed [COORD_WIDTH-1:0] v);
		logic signed [P_W-1:0] t;
		t = m * v + P_W'(64'sd536870912);
		return t >>> 30;
	endfunction

	// rounded products
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0] <= mq(mat.m00, vx); p_s1[1] <= mq(mat.m01, vy); p_s1[2] <= mq(mat.m02, vz);
			p_s1[3] <= mq(mat.m10, vx); p_s1[4] <= mq(mat.m11, vy); p_s1[5] <= mq(mat.m12, vz);
			p_s1[6] <= mq(mat.m20, vx); p_s1[7] <= mq(mat.m21, vy); p_s1[8] <= mq(mat.m22, vz);
		end
	end

	// sum and saturate
	always_ff @(posedge clk) begin
		if (en) begin
			rx <= COORD_WIDTH'(sat96(96'(p_s1[0]) + 96'(p_s1[1]) + 96'(p_s1[2]), COORD_WIDTH));
			ry <= COORD_WIDTH'(sat96(96'(p_s1[3]) + 96'(p_s1[4]) + 96'(p_s1[5]), COORD_WIDTH));
			rz <= COORD_WIDTH'(sat96(96'(p_s1[6]) + 96'(p_s1[7]) + 96'(p_s1[8]), COORD_WIDTH));
		end
	end

endmodule

>>> rtl/erbj_cross.sv
// ============================================================================
// erbj_cross
// Two-stage axis cross product, axis Q1.14 times coordinate, rounded and
// saturated to the coordinate width.
// ============================================================================
module erbj_cross
	import erbj_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          en,
	input  axis_t                         axis,
	input  logic signed [COORD_WIDTH-1:0] ux,
	input  logic signed [COORD_WIDTH-1:0] uy,
	input  logic signed [COORD_WIDTH-1:0] uz,
	output logic signed [COORD_WIDTH-1:0] rx,
	output logic signed [COORD_WIDTH-1:0] ry,
	output logic signed [COORD_WIDTH-1:0] rz
);

	localparam int P_W = COORD_WIDTH + 17;

	logic signed [P_W-1:0] p_s1 [6];
	logic signed [15:0] a0, a1, a2;

	assign a0 = axis[15:0];
	assign a1 = axis[31:16];
	assign a2 = axis[47:32];

	// products
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0] <= a1 * uz; p_s1[1] <= a2 * uy;
			p_s1[2] <= a2 * ux; p_s1[3] <= a0 * uz;
			p_s1[4] <= a0 * uy; p_s1[5] <= a1 * ux;
		end
	end

	function automatic logic signed [COORD_WIDTH-1:0] fin(input logic signed [P_W-1:0] a,
			input logic signed [P_W-1:0] b);
		logic signed [95:0] t;
		t = (96'(a) - 96'(b) + 96'sd8192) >>> 14;
		return COORD_WIDTH'(sat96(t, COORD_WIDTH));
	endfunction

	// difference, round, saturate
	always_ff @(posedge clk) begin
		if (en) begin
			rx <= fin(p_s1[0], p_s1[1]);
			ry <= fin(p_s1[2], p_s1[3]);
			rz <= fin(p_s1[4], p_s1[5]);
		end
	end

endmodule

>>> rtl/euler_rigid_body_point_jacobian.sv
// ============================================================================
// euler_rigid_body_point_jacobian
// Global point/vector and rotational Jacobian columns of an Euler-angle
// rigid body, fully pipelined.
// ============================================================================
// Throughput: one item per cycle; the whole pipeline advances together
// and halts only when the output register holds an untaken item.
// Reset clears all valid bits and loads the axes x, y, z for alpha, beta,
// gamma; data registers are not reset.
module euler_rigid_body_point_jacobian
	import erbj_pkg::*;
#(
	parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	erbj_cfg_if.sink   cfg,
	erbj_in_if.sink    in_ch,
	erbj_out_if.source out_ch
);

	localparam int MAT_LAT = CORDIC_STAGES + 3;   // registers after input stage
	localparam int LAT     = MAT_LAT + 11;
	localparam int CW      = COORD_WIDTH;

	axis_t axis_a_q, axis_b_q, axis_g_q;

	// configuration registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_a_q <= 48'd16384;
			axis_b_q <= 48'd1073741824;
			axis_g_q <= 48'd70368744177664;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_AXIS_ALPHA: axis_a_q <= cfg.data;
				REG_AXIS_BETA:  axis_b_q <= cfg.data;
				REG_AXIS_GAMMA: axis_g_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// global enable: pipeline moves unless the output holds an untaken item
	logic en;
	logic [LAT:0] v_s;
	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else if (en)
			v_s <= {v_s[LAT-1:0], in_ch.valid};
	end
	assign out_ch.valid = v_s[LAT];

	function automatic logic signed [CW-1:0] in_sat(input logic signed [IO_W-1:0] v);
		return CW'(sat96(96'(v), CW));
	endfunction

	// matrices
	mat_t ma, mb, mc;
	erbj_mat #(.CORDIC_STAGES(CORDIC_STAGES)) u_ma (.clk, .en, .axis(axis_a_q),
		.angle(in_ch.angle_alpha), .mat(ma));
	erbj_mat #(.CORDIC_STAGES(CORDIC_STAGES)) u_mb (.clk, .en, .axis(axis_b_q),
		.angle(in_ch.angle_beta), .mat(mb));
	erbj_mat #(.CORDIC_STAGES(CORDIC_STAGES)) u_mc (.clk, .en, .axis(axis_g_q),
		.angle(in_ch.angle_gamma), .mat(mc));

	// delay line for func, pos, loc until matrices are ready
	logic                 fn_d [LAT];
	logic signed [CW-1:0] px_d [LAT], py_d [LAT], pz_d [LAT];
	logic signed [CW-1:0] lx_d [MAT_LAT+1], ly_d [MAT_LAT+1], lz_d [MAT_LAT+1];
	always_ff @(posedge clk) begin
		if (en) begin
			fn_d[0] <= in_ch.func;
			px_d[0] <= in_sat(in_ch.pos_x);
			py_d[0] <= in_sat(in_ch.pos_y);
			pz_d[0] <= in_sat(in_ch.pos_z);
			lx_d[0] <= in_sat(in_ch.loc_x);
			ly_d[0] <= in_sat(in_ch.loc_y);
			lz_d[0] <= in_sat(in_ch.loc_z);
			for (int i = 1; i < LAT; i++) begin
				fn_d[i] <= fn_d[i-1];
				px_d[i] <= px_d[i-1];
				py_d[i] <= py_d[i-1];
				pz_d[i] <= pz_d[i-1];
			end
			for (int i = 1; i <= MAT_LAT; i++) begin
				lx_d[i] <= lx_d[i-1];
				ly_d[i] <= ly_d[i-1];
				lz_d[i] <= lz_d[i-1];
			end
		end
	end

	// matrix delay lines: Mb and Mc delayed to meet the rotated vectors that use them
	mat_t mb_d [4], mc_d [6];
	always_ff @(posedge clk) begin
		if (en) begin
			mb_d[0] <= mb;
			mc_d[0] <= mc;
			for (int i = 1; i < 4; i++)
				mb_d[i] <= mb_d[i-1];
			for (int i = 1; i < 6; i++)
				mc_d[i] <= mc_d[i-1];
		end
	end

	// loc aligned with ma: both reach the first rotation together
	logic signed [CW-1:0] u1x, u1y, u1z, u2x, u2y, u2z, u3x, u3y, u3z;
	erbj_mv #(.COORD_WIDTH(CW)) u_mv1 (.clk, .en, .mat(ma),
		.vx(lx_d[MAT_LAT]), .vy(ly_d[MAT_LAT]), .vz(lz_d[MAT_LAT]),
		.rx(u1x), .ry(u1y), .rz(u1z));
	erbj_mv #(.COORD_WIDTH(CW)) u_mv2 (.clk, .en, .mat(mb_d[1]),
		.vx(u1x), .vy(u1y), .vz(u1z), .rx(u2x), .ry(u2y), .rz(u2z));
	erbj_mv #(.COORD_WIDTH(CW)) u_mv3 (.clk, .en, .mat(mc_d[3]),
		.vx(u2x), .vy(u2y), .vz(u2z), .rx(u3x), .ry(u3y), .rz(u3z));

	// alpha column: cross on u1, then Mb, then Mc
	logic signed [CW-1:0] cax, cay, caz, dax1, day1, daz1, dax, day, daz;
	erbj_cross #(.COORD_WIDTH(CW)) u_cra (.clk, .en, .axis(axis_a_q),
		.ux(u1x), .uy(u1y), .uz(u1z), .rx(cax), .ry(cay), .rz(caz));
	erbj_mv #(.COORD_WIDTH(CW)) u_mva1 (.clk, .en, .mat(mb_d[3]),
		.vx(cax), .vy(cay), .vz(caz), .rx(dax1), .ry(day1), .rz(daz1));
	erbj_mv #(.COORD_WIDTH(CW)) u_mva2 (.clk, .en, .mat(mc_d[5]),
		.vx(dax1), .vy(day1), .vz(daz1), .rx(dax), .ry(day), .rz(daz));

	// beta column
	logic signed [CW-1:0] cbx, cby, cbz, dbx, dby, dbz;
	erbj_cross #(.COORD_WIDTH(CW)) u_crb (.clk, .en, .axis(axis_b_q),
		.ux(u2x), .uy(u2y), .uz(u2z), .rx(cbx), .ry(cby), .rz(cbz));
	erbj_mv #(.COORD_WIDTH(CW)) u_mvb (.clk, .en, .mat(mc_d[5]),
		.vx(cbx), .vy(cby), .vz(cbz), .rx(dbx), .ry(dby), .rz(dbz));

	// gamma column
	logic signed [CW-1:0] dcx, dcy, dcz;
	erbj_cross #(.COORD_WIDTH(CW)) u_crc (.clk, .en, .axis(axis_g_q),
		.ux(u3x), .uy(u3y), .uz(u3z), .rx(dcx), .ry(dcy), .rz(dcz));

	// align results: u3, da, db and dc delayed to meet at the output register
	logic signed [CW-1:0] u3_d [4][3], da_d [2][3], db_d [2][3], dc_d [2][3];
	always_ff @(posedge clk) begin
		if (en) begin
			u3_d[0][0] <= u3x; u3_d[0][1] <= u3y; u3_d[0][2] <= u3z;
			da_d[0][0] <= dax; da_d[0][1] <= day; da_d[0][2] <= daz;
			db_d[0][0] <= dbx; db_d[0][1] <= dby; db_d[0][2] <= dbz;
			dc_d[0][0] <= dcx; dc_d[0][1] <= dcy; dc_d[0][2] <= dcz;
			for (int i = 1; i < 4; i++)
				u3_d[i] <= u3_d[i-1];
			da_d[1] <= da_d[0];
			db_d[1] <= db_d[0];
			dc_d[1] <= dc_d[0];
		end
	end

	function automatic logic signed [IO_W-1:0] o32(input logic signed [CW-1:0] v);
		return IO_W'(sat96(96'(v), IO_W));
	endfunction

	function automatic logic signed [IO_W-1:0] gsum(input logic f,
			input logic signed [CW-1:0] u, input logic signed [CW-1:0] p);
		logic signed [95:0] s;
		s = f ? 96'(u) : sat96(96'(u) + 96'(p), CW);
		return IO_W'(sat96(s, IO_W));
	endfunction

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			out_ch.glob_x   <= gsum(fn_d[LAT-1], u3_d[3][0], px_d[LAT-1]);
			out_ch.glob_y   <= gsum(fn_d[LAT-1], u3_d[3][1], py_d[LAT-1]);
			out_ch.glob_z   <= gsum(fn_d[LAT-1], u3_d[3][2], pz_d[LAT-1]);
			out_ch.dalpha_x <= o32(da_d[1][0]);
			out_ch.dalpha_y <= o32(da_d[1][1]);
			out_ch.dalpha_z <= o32(da_d[1][2]);
			out_ch.dbeta_x  <= o32(db_d[1][0]);
			out_ch.dbeta_y  <= o32(db_d[1][1]);
			out_ch.dbeta_z  <= o32(db_d[1][2]);
			out_ch.dgamma_x <= o32(dc_d[1][0]);
			out_ch.dgamma_y <= o32(dc_d[1][1]);
			out_ch.dgamma_z <= o32(dc_d[1][2]);
		end
	end

	// a held item stays while not taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.glob_x))
		else $error("held item changed");
	// entry valid bit follows the input valid whenever the pipeline moves
	a_track: assert property (@(posedge clk) disable iff (!arst_n)
		en |=> v_s[0] == $past(in_ch.valid))
		else $error("valid lost at entry");
	// pipeline frozen during a stall
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s))
		else $error("pipeline moved during stall");

endmodule

>>> verif/euler_rigid_body_point_jacobian_tb.sv
// ----------------------------------------------------------------------------
// euler_rigid_body_point_jacobian_tb
// Self-checking bench for the rigid body point transform and Jacobian block.
// Sends directed items and then random ones under several axis settings,
// with random gaps on both channels. Each result is checked field by field
// against a bit-exact fixed-point rotation predictor, or typed values.
// ----------------------------------------------------------------------------
module euler_rigid_body_point_jacobian_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import erbj_pkg::*;

	localparam int  CW          = 32;
	localparam int  STAGES      = 16;
	localparam int  DRAIN_WAIT  = STAGES + 24;
	localparam int  LONG_HOLD   = 300;
	localparam int  CYCLE_LIMIT = 400000;
	localparam int  N_PHASE     = 6;
	localparam int  N_PER_PHASE = 160;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic        func;
		logic [31:0] pos [3];
		logic [15:0] ang [3];
		logic [31:0] loc [3];
	} body_item_t;

	typedef logic [11:0][31:0] jac_res_t;

	typedef struct {
		body_item_t  item;
		bit          typed;
		logic [31:0] glob [3];
	} dir_row_t;

	logic clk;
	logic arst_n;
	erbj_cfg_if cfg ();
	erbj_in_if  in_ch ();
	erbj_out_if out_ch ();

	euler_rigid_body_point_jacobian u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	axis_t    axis_a, axis_b, axis_c;
	jac_res_t expected_q [$];
	int       n_err;
	int       n_items;
	int       n_results;
	int       cycle;
	bit       hold_req;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle);
			$display("euler_rigid_body_point_jacobian_tb failed");
			$finish;
		end
	end

	// ---------------- predictor ----------------
	function automatic longint satw(input longint v, input int w);
		longint lim;
		lim = longint'(1) <<< (w - 1);
		if (v >= lim)
			return lim - 1;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic longint qmul(input longint p, input longint q);
		return (p * q + 64'sd536870912) >>> 30;
	endfunction

	function automatic longint mvmul(input longint m, input longint v);
		longint vh, vl;
		vh = v >>> 30;
		vl = v & 64'h3FFF_FFFF;
		return m * vh + ((m * vl + 64'sd536870912) >>> 30);
	endfunction

	function automatic longint axis_comp(input axis_t ax, input int k);
		logic [15:0] c;
		c = ax[16*k +: 16];
		return longint'($signed(c));
	endfunction

	function automatic void rot_matrix(input axis_t ax, input logic [15:0] ang,
			output longint m [9]);
		longint atan_t [16];
		longint h, x, y, z, dx, dy, w, qx, qy, qz;
		atan_t = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
			16775851, 8388437, 4194283, 2097149, 1048576, 524288,
			262144, 131072, 65536, 32768};
		h = longint'($signed(ang)) * 131072;
		// fold the half angle into the cordic range
		if (h > 64'sd1686629713)
			h = h - 64'sd3373259426;
		else if (h < -64'sd1686629713)
			h = h + 64'sd3373259426;
		x = 64'sd652032874;
		y = 0;
		z = h;
		for (int i = 0; i < STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx; y = y + dy; z = z - atan_t[i];
			end else begin
				x = x + dx; y = y - dy; z = z + atan_t[i];
			end
		end
		w  = x;
		qx = (axis_comp(ax, 0) * y + 8192) >>> 14;
		qy = (axis_comp(ax, 1) * y + 8192) >>> 14;
		qz = (axis_comp(ax, 2) * y + 8192) >>> 14;
		m[0] = satw(64'sd1073741824 - 2 * (qmul(qy, qy) + qmul(qz, qz)), 32);
		m[1] = satw(2 * (qmul(qx, qy) - qmul(qz, w)), 32);
		m[2] = satw(2 * (qmul(qx, qz) + qmul(qy, w)), 32);
		m[3] = satw(2 * (qmul(qx, qy) + qmul(qz, w)), 32);
		m[4] = satw(64'sd1073741824 - 2 * (qmul(qx, qx) + qmul(qz, qz)), 32);
		m[5] = satw(2 * (qmul(qy, qz) - qmul(qx, w)), 32);
		m[6] = satw(2 * (qmul(qx, qz) - qmul(qy, w)), 32);
		m[7] = satw(2 * (qmul(qy, qz) + qmul(qx, w)), 32);
		m[8] = satw(64'sd1073741824 - 2 * (qmul(qx, qx) + qmul(qy, qy)), 32);
	endfunction

	function automatic void rotate(input longint m [9], input longint v [3],
			output longint r [3]);
		for (int i = 0; i < 3; i++)
			r[i] = satw(mvmul(m[3*i], v[0]) + mvmul(m[3*i+1], v[1])
				+ mvmul(m[3*i+2], v[2]), CW);
	endfunction

	function automatic void axis_cross(input axis_t ax, input longint u [3],
			output longint r [3]);
		longint a0, a1, a2;
		a0 = axis_comp(ax, 0);
		a1 = axis_comp(ax, 1);
		a2 = axis_comp(ax, 2);
		r[0] = satw((a1 * u[2] - a2 * u[1] + 8192) >>> 14, CW);
		r[1] = satw((a2 * u[0] - a0 * u[2] + 8192) >>> 14, CW);
		r[2] = satw((a0 * u[1] - a1 * u[0] + 8192) >>> 14, CW);
	endfunction

	function automatic jac_res_t predict_jacobian(input body_item_t it);
		longint ma [9], mb [9], mc [9];
		longint pos [3], loc [3], u1 [3], u2 [3], u3 [3];
		longint da [3], db [3], dc [3], t [3];
		jac_res_t r;
		for (int i = 0; i < 3; i++) begin
			pos[i] = satw(longint'($signed(it.pos[i])), CW);
			loc[i] = satw(longint'($signed(it.loc[i])), CW);
		end
		rot_matrix(axis_a, it.ang[0], ma);
		rot_matrix(axis_b, it.ang[1], mb);
		rot_matrix(axis_c, it.ang[2], mc);
		rotate(ma, loc, u1);
		rotate(mb, u1, u2);
		rotate(mc, u2, u3);
		axis_cross(axis_a, u1, t);
		rotate(mb, t, da);
		rotate(mc, da, t);
		da = t;
		axis_cross(axis_b, u2, t);
		rotate(mc, t, db);
		axis_cross(axis_c, u3, dc);
		for (int i = 0; i < 3; i++) begin
			r[i]     = 32'(satw(it.func ? u3[i] : satw(u3[i] + pos[i], CW), 32));
			r[3 + i] = 32'(satw(da[i], 32));
			r[6 + i] = 32'(satw(db[i], 32));
			r[9 + i] = 32'(satw(dc[i], 32));
		end
		return r;
	endfunction

	function automatic string field_name(input int i);
		case (i)
			0: return "glob_x";   1: return "glob_y";   2: return "glob_z";
			3: return "dalpha_x"; 4: return "dalpha_y"; 5: return "dalpha_z";
			6: return "dbeta_x";  7: return "dbeta_y";  8: return "dbeta_z";
			9: return "dgamma_x"; 10: return "dgamma_y"; default: return "dgamma_z";
		endcase
	endfunction

	// ---------------- receiver and checker ----------------
	int  rx_wait;
	int  rx_draw;
	int  hold_cnt;
	bit  hold_done;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			rx_wait      <= 0;
			hold_cnt     <= 0;
			hold_done    <= 1'b0;
		end else begin
			// compare an accepted item with the oldest expectation
			if (out_ch.valid && out_ch.ready) begin
				jac_res_t got, exp_r;
				got = {out_ch.dgamma_z, out_ch.dgamma_y, out_ch.dgamma_x,
					out_ch.dbeta_z, out_ch.dbeta_y, out_ch.dbeta_x,
					out_ch.dalpha_z, out_ch.dalpha_y, out_ch.dalpha_x,
					out_ch.glob_z, out_ch.glob_y, out_ch.glob_x};
				n_results++;
				if (expected_q.size() == 0) begin
					$error("result item with no expectation waiting");
					n_err++;
				end else begin
					exp_r = expected_q.pop_front();
					for (int i = 0; i < 12; i++)
						if (got[i] !== exp_r[i]) begin
							$error("%s expected %0d got %0d", field_name(i),
								$signed(exp_r[i]), $signed(got[i]));
							n_err++;
						end
				end
			end
			// ready: long hold once on request, else random waits per item
			if (hold_req && !hold_done) begin
				out_ch.ready <= 1'b0;
				if (hold_cnt == LONG_HOLD)
					hold_done <= 1'b1;
				hold_cnt <= hold_cnt + 1;
			end else if (out_ch.valid && out_ch.ready) begin
				rx_draw      = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 11));
				out_ch.ready <= (rx_draw == 0);
				rx_wait      <= (rx_draw == 0) ? 0 : rx_draw - 1;
			end else if (rx_wait > 0) begin
				rx_wait      <= rx_wait - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// ---------------- sender side ----------------
	task automatic write_axis(input logic [1:0] idx, input axis_t val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			REG_AXIS_ALPHA: axis_a = val;
			REG_AXIS_BETA:  axis_b = val;
			REG_AXIS_GAMMA: axis_c = val;
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic send_item(input body_item_t it, input int gap, input bit typed,
			input jac_res_t typed_res);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.func        <= it.func;
		in_ch.pos_x       <= it.pos[0];
		in_ch.pos_y       <= it.pos[1];
		in_ch.pos_z       <= it.pos[2];
		in_ch.angle_alpha <= it.ang[0];
		in_ch.angle_beta  <= it.ang[1];
		in_ch.angle_gamma <= it.ang[2];
		in_ch.loc_x       <= it.loc[0];
		in_ch.loc_y       <= it.loc[1];
		in_ch.loc_z       <= it.loc[2];
		do @(posedge clk); while (!in_ch.ready);
		expected_q.push_back(typed ? typed_res : predict_jacobian(it));
		n_items++;
	endtask

	function automatic logic [31:0] rand_coord(input int kind);
		case (kind)
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
			2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
		endcase
	endfunction

	function automatic body_item_t rand_item();
		body_item_t it;
		int kind;
		kind    = $urandom_range(0, 7);
		it.func = 1'($urandom_range(0, 1));
		for (int i = 0; i < 3; i++) begin
			it.pos[i] = rand_coord(kind < 2 ? 0 : (kind == 2 ? 2 : 1));
			it.loc[i] = rand_coord(kind < 2 ? 0 : (kind == 3 ? 2 : 3));
			it.ang[i] = (kind < 4) ? 16'($urandom()) :
				16'($signed($urandom_range(0, 25736)) - 12868);
		end
		return it;
	endfunction

	function automatic axis_t unit_axis();
		axis_t ax;
		logic [15:0] one;
		one = $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
		ax  = '0;
		ax[16 * $urandom_range(0, 2) +: 16] = one;
		return ax;
	endfunction

	function automatic axis_t phase_axis(input int ph);
		case (ph)
			0: return unit_axis();
			1: return {16'($urandom_range(0, 16384) - 8192),
				16'($urandom_range(0, 16384) - 8192), 16'($urandom_range(0, 16384) - 8192)};
			2: return 48'({$urandom(), $urandom()});
			3: return '0;
			4: return 48'hFFFF_FFFF_FFFF;
			default: return $urandom_range(0, 1) ? 48'h8000_8000_8000 : 48'h7FFF_7FFF_7FFF;
		endcase
	endfunction

	// ---------------- main sequence ----------------
	initial begin
		dir_row_t   rows [$];
		dir_row_t   row;
		body_item_t it;
		jac_res_t   tr;
		n_err        = 0;
		n_items      = 0;
		n_results    = 0;
		hold_req     = 1'b0;
		axis_a       = 48'd16384;
		axis_b       = 48'd1073741824;
		axis_c       = 48'd70368744177664;
		arst_n       <= 1'b0;
		cfg.valid    <= 1'b0;
		cfg.index    <= REG_AXIS_ALPHA;
		cfg.data     <= '0;
		in_ch.valid  <= 1'b0;
		in_ch.func   <= 1'b0;
		in_ch.pos_x  <= '0; in_ch.pos_y <= '0; in_ch.pos_z <= '0;
		in_ch.angle_alpha <= '0; in_ch.angle_beta <= '0; in_ch.angle_gamma <= '0;
		in_ch.loc_x  <= '0; in_ch.loc_y <= '0; in_ch.loc_z <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows: zero local point gives exact results
		row.item.func = 1'b0;
		row.item.pos  = '{0, 0, 0};
		row.item.ang  = '{0, 0, 0};
		row.item.loc  = '{0, 0, 0};
		row.typed     = 1'b1;
		row.glob      = '{0, 0, 0};
		rows.push_back(row);
		row.item.pos  = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
		row.item.ang  = '{16'h7FFF, 16'h8000, 16'h1234};
		row.glob      = row.item.pos;
		rows.push_back(row);
		row.item.pos  = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
		row.glob      = row.item.pos;
		rows.push_back(row);
		row.item.func = 1'b1;
		row.glob      = '{0, 0, 0};
		rows.push_back(row);
		// predicted rows: unit vector, extremes, half-angle fold edges
		row.typed     = 1'b0;
		row.item.func = 1'b0;
		row.item.pos  = '{32'h0001_0000, 32'hFFFF_0000, 0};
		row.item.loc  = '{32'h0001_0000, 0, 0};
		row.item.ang  = '{0, 0, 0};
		rows.push_back(row);
		row.item.ang  = '{16'd12868, 16'd12869, -16'sd12868};
		rows.push_back(row);
		row.item.ang  = '{-16'sd12869, 16'h7FFF, 16'h8000};
		rows.push_back(row);
		row.item.ang  = '{16'h1922, 16'h0C91, 16'hE6DE};
		row.item.loc  = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
		row.item.pos  = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
		rows.push_back(row);
		row.item.loc  = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
		row.item.pos  = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
		rows.push_back(row);
		row.item.func = 1'b1;
		rows.push_back(row);
		row.item.ang  = '{16'hFFFF, 16'h0001, 16'h5555};
		row.item.loc  = '{32'hFFFF_FFFF, 32'h0000_0001, 32'hAAAA_5555};
		rows.push_back(row);
		foreach (rows[r]) begin
			tr = '0;
			for (int i = 0; i < 3; i++)
				tr[i] = rows[r].glob[i];
			send_item(rows[r].item, $urandom_range(0, 11), rows[r].typed, tr);
		end

		// random phases, each under fresh axis settings written while idle
		for (int ph = 0; ph < N_PHASE; ph++) begin
			in_ch.valid <= 1'b0;
			wait_idle();
			write_axis(REG_AXIS_ALPHA, phase_axis(ph));
			write_axis(REG_AXIS_BETA, phase_axis(ph));
			write_axis(REG_AXIS_GAMMA, phase_axis(ph));
			if (ph == 2)
				write_axis(REG_UNUSED, 48'({$urandom(), $urandom()}));
			if (ph == 1)
				hold_req = 1'b1;
			for (int n = 0; n < N_PER_PHASE; n++) begin
				it = rand_item();
				send_item(it, ($urandom_range(0, 2) == 0 || (n >= 40 && n < 80)) ? 0 :
					$urandom_range(0, 11), 1'b0, '0);
			end
		end
		in_ch.valid <= 1'b0;
		wait_idle();

		$display("sent %0d items over %0d axis settings, checked %0d results",
			n_items, N_PHASE + 1, n_results);
		$display("covered fold edges, saturation extremes, zero and non-unit axes");
		if (n_err == 0 && expected_q.size() == 0) begin
			$display("euler_rigid_body_point_jacobian_tb passed");
		end else begin
			if (expected_q.size() != 0)
				$error("%0d expected results never arrived", expected_q.size());
			$display("euler_rigid_body_point_jacobian_tb failed");
		end
		$finish;
	end

endmodule

>>> euler_rigid_body_point_jacobian.f
rtl/erbj_pkg.sv
rtl/erbj_if.sv
rtl/erbj_mat.sv
rtl/erbj_mv.sv
rtl/erbj_cross.sv
rtl/euler_rigid_body_point_jacobian.sv
verif/euler_rigid_body_point_jacobian_tb.sv
